FILE: hdl/chacha20_block_keystream_macros.svh
// Assertion helpers shared by the keystream RTL.
// Each use expects clk and arst_n in scope.
`ifndef CHACHA20_BLOCK_KEYSTREAM_MACROS_SVH
`define CHACHA20_BLOCK_KEYSTREAM_MACROS_SVH

// Same-cycle implication
`define CC20KS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CC20KS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/cc20ks_pkg.sv
`default_nettype none

package cc20ks_pkg;

	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int WORD_W            = 32;
	localparam int NUM_WORDS         = 16;
	localparam int OUT_BEATS         = 8;
	localparam int OUT_W             = 2 * WORD_W;
	localparam logic [2:0] PHASE_LAST = 3'd7;

	// Sixteen-word block state, word 0 in the low bits
	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

	// Chain control, common to every cell
	typedef struct packed {
		logic       run;   // cells step this cycle
		logic       shift; // cells hand their state to the neighbor
		logic [2:0] phase; // step within the double round
	} ctl_t;

	// Register map, by 64-bit slot
	typedef enum logic [2:0] {
		REG_KEY0     = 3'd0,
		REG_KEY1     = 3'd1,
		REG_KEY2     = 3'd2,
		REG_KEY3     = 3'd3,
		REG_NONCE_LO = 3'd4,
		REG_NONCE_HI = 3'd5
	} reg_idx_t;

	localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
	localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
	localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
	localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

	// Initial state from constants, key, counter and nonce
	function automatic state_t cc20ks_init(
		logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
		logic [63:0] nlo, logic [31:0] nhi, logic [31:0] ctr);
		state_t s;
		s[0]  = SIGMA0;
		s[1]  = SIGMA1;
		s[2]  = SIGMA2;
		s[3]  = SIGMA3;
		s[4]  = k0[31:0];
		s[5]  = k0[63:32];
		s[6]  = k1[31:0];
		s[7]  = k1[63:32];
		s[8]  = k2[31:0];
		s[9]  = k2[63:32];
		s[10] = k3[31:0];
		s[11] = k3[63:32];
		s[12] = ctr;
		s[13] = nlo[31:0];
		s[14] = nlo[63:32];
		s[15] = nhi;
		return s;
	endfunction

	// One line of four parallel quarter rounds.
	// phase[2]: diagonal set; phase[0]: c/b line vs a/d line;
	// phase[1]: second pair of rotations (8, 7) vs first (16, 12).
	function automatic state_t cc20ks_step(state_t s, logic [2:0] phase);
		state_t      r;
		logic [1:0]  ib;
		logic [1:0]  ic;
		logic [1:0]  id;
		logic [3:0]  xa;
		logic [3:0]  xb;
		logic [3:0]  xc;
		logic [3:0]  xd;
		logic [31:0] sum;
		logic [31:0] mx;
		r = s;
		for (int i = 0; i < 4; i++) begin
			ib = phase[2] ? 2'(i + 1) : 2'(i);
			ic = phase[2] ? 2'(i + 2) : 2'(i);
			id = phase[2] ? 2'(i + 3) : 2'(i);
			xa = 4'(i);
			xb = {2'b01, ib};
			xc = {2'b10, ic};
			xd = {2'b11, id};
			if (!phase[0]) begin
				sum    = s[xa] + s[xb];
				mx     = s[xd] ^ sum;
				r[xa]  = sum;
				r[xd]  = phase[1] ? {mx[23:0], mx[31:24]} : {mx[15:0], mx[31:16]};
			end else begin
				sum    = s[xc] + s[xd];
				mx     = s[xb] ^ sum;
				r[xc]  = sum;
				r[xb]  = phase[1] ? {mx[24:0], mx[31:25]} : {mx[19:0], mx[31:20]};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/chacha20_block_keystream.sv
// ChaCha20 keystream generator.
// Slave stream: one beat per block, s_tdata[31:0] is the block counter.
// Master stream: eight beats per block, 64-bit keystream words, low half
// the even state word; m_tuser is the word position, m_tlast marks the 8th.
// APB port: key and nonce in six 64-bit registers at byte offsets 0..40;
// write them only while no block is in flight.
// A row of DOUBLE_ROUNDS cells, each doing one double round as eight line
// steps of four quarter rounds in parallel; all cells step together on a
// shared eight-phase counter and pass their blocks on at the phase wrap.
// Blocks enter the row one behind another, so several are in flight at once,
// and the eight output beats match the cell period. Each block passes
// the input register, each cell in turn and the output stage.
// A one-entry input register lets the next counter be taken while blocks
// are still in the row. If the receiver stalls, the row halts at the
// hand-off until the output stage has sent all eight beats.
// Reset clears the key and nonce registers, the valid bits and the phase counter.
`default_nettype none
`include "chacha20_block_keystream_macros.svh"

module chacha20_block_keystream #(
	parameter int DOUBLE_ROUNDS = cc20ks_pkg::DOUBLE_ROUNDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] block_counter
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // [63:0] keystream_word
	output logic [2:0]       m_tuser,  // [2:0] word_index
	output logic             m_tlast,  // last_word
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import cc20ks_pkg::*;

	logic [63:0]  key0_q;
	logic [63:0]  key1_q;
	logic [63:0]  key2_q;
	logic [63:0]  key3_q;
	logic [63:0]  nonce_lo_q;
	logic [31:0]  nonce_hi_q;
	logic         wr_en;
	reg_idx_t     reg_sel;

	logic         in_valid_q;
	logic [31:0]  in_ctr_q;
	logic [2:0]   phase_q;
	logic         out_free;
	logic         load;
	ctl_t         ctl;

	state_t                  chain_state [DOUBLE_ROUNDS+1];
	logic [31:0]             chain_ctr   [DOUBLE_ROUNDS+1];
	logic [DOUBLE_ROUNDS:0]  chain_valid;

	// configuration registers
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q     <= '0;
			key1_q     <= '0;
			key2_q     <= '0;
			key3_q     <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_KEY0:     key0_q     <= pwdata;
				REG_KEY1:     key1_q     <= pwdata;
				REG_KEY2:     key2_q     <= pwdata;
				REG_KEY3:     key3_q     <= pwdata;
				REG_NONCE_LO: nonce_lo_q <= pwdata;
				REG_NONCE_HI: nonce_hi_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_KEY0:     prdata = key0_q;
			REG_KEY1:     prdata = key1_q;
			REG_KEY2:     prdata = key2_q;
			REG_KEY3:     prdata = key3_q;
			REG_NONCE_LO: prdata = nonce_lo_q;
			REG_NONCE_HI: prdata = {32'd0, nonce_hi_q};
			default:      prdata = '0;
		endcase
	end

	// row control: halt only at the hand-off when the output is busy
	assign ctl.run   = !(phase_q == PHASE_LAST && chain_valid[DOUBLE_ROUNDS] && !out_free);
	assign ctl.shift = ctl.run && phase_q == PHASE_LAST;
	assign ctl.phase = phase_q;
	assign load      = ctl.shift && chain_valid[DOUBLE_ROUNDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (ctl.run) begin
			phase_q <= 3'(phase_q + 3'd1);
		end
	end

	// input holding register
	assign s_tready = !in_valid_q || ctl.shift;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_ctr_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_valid_q <= 1'b1;
		end else if (ctl.shift) begin
			in_valid_q <= 1'b0;
		end
	end

	// head of the row
	assign chain_state[0] = cc20ks_init(key0_q, key1_q, key2_q, key3_q,
		nonce_lo_q, nonce_hi_q, in_ctr_q);
	assign chain_ctr[0]   = in_ctr_q;
	assign chain_valid[0] = in_valid_q;

	// row of double-round cells
	for (genvar g = 0; g < DOUBLE_ROUNDS; g++) begin : g_cell
		cc20ks_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.up_state (chain_state[g]),
			.up_valid (chain_valid[g]),
			.up_ctr   (chain_ctr[g]),
			.dn_state (chain_state[g+1]),
			.dn_valid (chain_valid[g+1]),
			.dn_ctr   (chain_ctr[g+1])
		);
	end

	// feed-forward and output beats
	cc20ks_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.fin_state (chain_state[DOUBLE_ROUNDS]),
		.fin_ctr   (chain_ctr[DOUBLE_ROUNDS]),
		.key0      (key0_q),
		.key1      (key1_q),
		.key2      (key2_q),
		.key3      (key3_q),
		.nonce_lo  (nonce_lo_q),
		.nonce_hi  (nonce_hi_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.free      (out_free)
	);

	`CC20KS_ASSERT_NOW(a_halt_only_blocked, !ctl.run, chain_valid[DOUBLE_ROUNDS] && !out_free, "row halted without a blocked result")
	`CC20KS_ASSERT_NEXT(a_in_held, in_valid_q && !ctl.shift, in_valid_q, "pending counter dropped")
	`CC20KS_ASSERT_NEXT(a_in_taken, s_tvalid && s_tready, in_valid_q, "accepted counter not held")
	`CC20KS_ASSERT_NEXT(a_load_first_beat, load, m_tvalid && m_tuser == 3'd0, "loaded block not at first beat")

endmodule

`default_nettype wire

FILE: hdl/cc20ks_cell.sv
`default_nettype none

// One double round: eight line steps over a period, then hand-off
module cc20ks_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cc20ks_pkg::ctl_t          ctl,
	input  wire cc20ks_pkg::state_t        up_state,
	input  wire logic                      up_valid,
	input  wire logic [31:0]               up_ctr,
	output cc20ks_pkg::state_t             dn_state,
	output logic                           dn_valid,
	output logic [31:0]                    dn_ctr
);
	import cc20ks_pkg::*;

	state_t      state_q;
	logic [31:0] ctr_q;
	logic        valid_q;
	state_t      step_d;

	// line step for this phase
	assign step_d = cc20ks_step(state_q, ctl.phase);

	// working state: iterate, or take the upstream block on hand-off
	always_ff @(posedge clk) begin
		if (ctl.run) begin
			state_q <= ctl.shift ? up_state : step_d;
			if (ctl.shift) begin
				ctr_q <= up_ctr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= up_valid;
		end
	end

	assign dn_state = step_d;
	assign dn_valid = valid_q;
	assign dn_ctr   = ctr_q;

endmodule

`default_nettype wire

FILE: hdl/cc20ks_out.sv
`default_nettype none

// Final feed-forward add and eight-beat serializer
module cc20ks_out (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire cc20ks_pkg::state_t   fin_state,
	input  wire logic [31:0]          fin_ctr,
	input  wire logic [63:0]          key0,
	input  wire logic [63:0]          key1,
	input  wire logic [63:0]          key2,
	input  wire logic [63:0]          key3,
	input  wire logic [63:0]          nonce_lo,
	input  wire logic [31:0]          nonce_hi,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [63:0]               m_tdata,  // [63:0] keystream_word
	output logic [2:0]                m_tuser,  // [2:0] word_index
	output logic                      m_tlast,
	output logic                      free
);
	import cc20ks_pkg::*;

	state_t                          init_d;
	logic [OUT_BEATS-1:0][OUT_W-1:0] sum_d;
	logic [OUT_BEATS-1:0][OUT_W-1:0] res_q;
	logic                            valid_q;
	logic [2:0]                      idx_q;
	logic                            beat;
	logic                            last_beat;

	// initial state rebuilt for the add
	assign init_d = cc20ks_init(key0, key1, key2, key3, nonce_lo, nonce_hi, fin_ctr);

	always_comb begin
		for (int k = 0; k < OUT_BEATS; k++) begin
			sum_d[k] = {fin_state[2*k+1] + init_d[2*k+1], fin_state[2*k] + init_d[2*k]};
		end
	end

	assign beat      = valid_q && m_tready;
	assign last_beat = idx_q == 3'(OUT_BEATS - 1);
	assign free      = !valid_q || (beat && last_beat);

	// result words: load all, shift one out per beat
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= sum_d;
		end else if (beat) begin
			for (int k = 0; k < OUT_BEATS - 1; k++) begin
				res_q[k] <= res_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (beat) begin
			valid_q <= !last_beat;
			idx_q   <= 3'(idx_q + 3'd1);
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q[0];
	assign m_tuser  = idx_q;
	assign m_tlast  = last_beat;

endmodule

`default_nettype wire
